### src/relay_stuck_monitor_assert.svh
// ----------------------------------------------------------------------------
// Relay stuck monitor assertion macros
// Concurrent assertion helpers that vanish when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef RELAY_STUCK_MONITOR_ASSERT_SVH
`define RELAY_STUCK_MONITOR_ASSERT_SVH

`ifndef SYNTHESIS
`define RSM_ASSERT_SAME(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) cond |-> prop) \
    else $error("relay_stuck_monitor: same-cycle check failed");
`define RSM_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) cond |=> prop) \
    else $error("relay_stuck_monitor: next-cycle check failed");
`else
`define RSM_ASSERT_SAME(label, clk, rst, cond, prop)
`define RSM_ASSERT_NEXT(label, clk, rst, cond, prop)
`endif

`endif

### src/rsm_pkg.sv
// ----------------------------------------------------------------------------
// Relay stuck monitor package
// Shared types, register map and constants of the relay stuck monitor.
// ----------------------------------------------------------------------------
package rsm_pkg;

  localparam int ADC_BITS = 12;

  // Division by six as a reciprocal multiply; exact for every ADC_BITS code.
  localparam int DIV6_SHIFT = ADC_BITS + 3;
  localparam logic [ADC_BITS:0] DIV6_MULT = (ADC_BITS + 1)'((2 ** DIV6_SHIFT + 5) / 6);

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;

  localparam logic [1:0] REG_STUCK_CONFIRM = 2'd0;
  localparam logic [1:0] REG_STUCK_HOLD    = 2'd1;
  localparam logic [1:0] REG_RETRY_LIMIT   = 2'd2;
  localparam logic [1:0] REG_RUN_LIMIT     = 2'd3;

  localparam logic [7:0]  STUCK_CONFIRM_RST = 8'd4;
  localparam logic [7:0]  STUCK_HOLD_RST    = 8'd200;
  localparam logic [7:0]  RETRY_LIMIT_RST   = 8'd3;
  localparam logic [15:0] RUN_LIMIT_RST     = 16'd3000;

  typedef struct packed {
    logic [ADC_BITS-1:0] feedback_a;
    logic [ADC_BITS-1:0] feedback_b;
    logic [ADC_BITS-1:0] battery_raw;
    logic                logic_on_a;
    logic                logic_on_b;
    logic                motor_running;
  } rsm_tick_t;

  typedef struct packed {
    logic phys_on_a;
    logic phys_on_b;
    logic stuck_a;
    logic stuck_b;
    logic wake_hold;
    logic block_motor;
    logic mark_released;
    logic normalize_exit;
    logic run_timeout;
  } rsm_result_t;

  typedef struct packed {
    logic phys_on_a;
    logic phys_on_b;
    logic logic_on_a;
    logic logic_on_b;
    logic motor_running;
  } rsm_cls_t;

  typedef struct packed {
    logic [7:0]  stuck_confirm;
    logic [7:0]  stuck_hold;
    logic [7:0]  retry_limit;
    logic [15:0] run_limit;
  } rsm_cfg_t;

  typedef struct packed {
    logic empty;
    logic full;
  } rsm_q_stat_t;

endpackage

### src/rsm_tick_if.sv
// ----------------------------------------------------------------------------
// Tick channel
// Valid/ready channel carrying one 10 ms tick of relay readings.
// ----------------------------------------------------------------------------
interface rsm_tick_if
  import rsm_pkg::*;
  ();
  logic      valid;
  logic      ready;
  rsm_tick_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/rsm_result_if.sv
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying the monitor flags of one tick.
// ----------------------------------------------------------------------------
interface rsm_result_if
  import rsm_pkg::*;
  ();
  logic        valid;
  logic        ready;
  rsm_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### src/rsm_front.sv
// ----------------------------------------------------------------------------
// Relay stuck monitor front end
// Takes ticks and compares each feedback with one sixth of the battery.
// ----------------------------------------------------------------------------
module rsm_front
  import rsm_pkg::*;
(
  rsm_tick_if.sink tick,
  input  logic     q_ready,
  output logic     q_push,
  output rsm_cls_t q_data
);

  logic [2*ADC_BITS:0] prod;
  logic [ADC_BITS-1:0] thr;

  assign prod = (2*ADC_BITS+1)'(tick.data.battery_raw) * (2*ADC_BITS+1)'(DIV6_MULT);
  assign thr  = ADC_BITS'(prod >> DIV6_SHIFT);

  assign tick.ready = q_ready;
  assign q_push     = tick.valid && q_ready;

  assign q_data.phys_on_a     = tick.data.feedback_a > thr;
  assign q_data.phys_on_b     = tick.data.feedback_b > thr;
  assign q_data.logic_on_a    = tick.data.logic_on_a;
  assign q_data.logic_on_b    = tick.data.logic_on_b;
  assign q_data.motor_running = tick.data.motor_running;

endmodule

### src/rsm_queue.sv
// ----------------------------------------------------------------------------
// Relay stuck monitor queue
// Short first-in first-out store between the front end and the back end.
// ----------------------------------------------------------------------------
module rsm_queue
  import rsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  rsm_cls_t    push_data,
  input  logic        pop,
  output rsm_cls_t    pop_data,
  output rsm_q_stat_t stat
);

  rsm_cls_t             mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QCNT_BITS-1:0] count;

  assign stat.empty = count == '0;
  assign stat.full  = count == QCNT_BITS'(QUEUE_DEPTH);
  assign pop_data   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/rsm_back.sv
// ----------------------------------------------------------------------------
// Relay stuck monitor back end
// Runs the stuck qualifiers and the motor run timer, and holds the result.
// ----------------------------------------------------------------------------
module rsm_back
  import rsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  rsm_cfg_t    cfg,
  input  rsm_q_stat_t q_stat,
  input  rsm_cls_t    q_data,
  output logic        q_pop,
  rsm_result_if.source result
);

  typedef struct packed {
    logic [7:0] count;
    logic       flag;
    logic [7:0] retries;
  } relay_t;

  typedef struct packed {
    relay_t rel;
    logic   became;
    logic   released;
  } qual_t;

  function automatic qual_t qualify(relay_t r, logic cmd_on, logic phys_on, rsm_cfg_t c);
    qual_t      q;
    logic [7:0] cnt;
    q.rel      = r;
    q.became   = 1'b0;
    q.released = 1'b0;
    cnt        = r.count;
    if (!r.flag) begin
      if (!cmd_on) begin
        if (phys_on) begin
          if (cnt < c.stuck_confirm) begin
            cnt = cnt + 8'd1;
          end
          if (cnt >= c.stuck_confirm) begin
            q.rel.flag  = 1'b1;
            q.rel.count = c.stuck_hold;
            q.became    = 1'b1;
          end else begin
            q.rel.count = cnt;
          end
        end else if (cnt != 8'd0) begin
          q.rel.count = cnt - 8'd1;
        end
      end
    end else if (cnt != 8'd0) begin
      q.rel.count = cnt - 8'd1;
    end else if (r.retries < c.retry_limit) begin
      q.rel.retries = r.retries + 8'd1;
      q.rel.flag    = 1'b0;
      q.released    = 1'b1;
    end
    return q;
  endfunction

  relay_t      rel_a;
  relay_t      rel_b;
  logic [15:0] run_ticks;
  qual_t       qa;
  qual_t       qb;
  relay_t      rel_a_next;
  relay_t      rel_b_next;
  logic [15:0] run_ticks_next;
  logic        timeout;
  logic        became;
  logic        released;

  assign q_pop = !q_stat.empty && (!result.valid || result.ready);

  always_comb begin
    qa = qualify(rel_a, q_data.logic_on_a, q_data.phys_on_a, cfg);
    qb = qualify(rel_b, q_data.logic_on_b, q_data.phys_on_b, cfg);
    rel_a_next     = rel_a;
    rel_b_next     = rel_b;
    became         = 1'b0;
    released       = 1'b0;
    timeout        = 1'b0;
    run_ticks_next = 16'd0;
    if (!q_data.motor_running) begin
      rel_a_next = qa.rel;
      rel_b_next = qb.rel;
      became     = qa.became || qb.became;
      released   = qa.released || qb.released;
    end else if (run_ticks < cfg.run_limit) begin
      run_ticks_next = run_ticks + 16'd1;
    end else begin
      timeout = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rel_a        <= '0;
      rel_b        <= '0;
      run_ticks    <= '0;
      result.valid <= 1'b0;
    end else begin
      if (q_pop) begin
        rel_a        <= rel_a_next;
        rel_b        <= rel_b_next;
        run_ticks    <= run_ticks_next;
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      result.data.phys_on_a      <= q_data.phys_on_a;
      result.data.phys_on_b      <= q_data.phys_on_b;
      result.data.stuck_a        <= rel_a_next.flag;
      result.data.stuck_b        <= rel_b_next.flag;
      result.data.wake_hold      <= rel_a_next.flag || rel_b_next.flag;
      result.data.block_motor    <= became;
      result.data.mark_released  <= released;
      result.data.normalize_exit <= became || timeout;
      result.data.run_timeout    <= timeout;
    end
  end

endmodule

### src/relay_stuck_monitor.sv
// An accepted tick enters the queue; the back end pops it into the result register.
// Throughput: one tick per cycle while results are taken; state updates on each pop.
// A two-entry queue and the result register let either side stall on its own.
// Reset (rst, synchronous) restores the register defaults and clears all counters,
// stuck marks and the queue; no clearing pass is needed.
// ----------------------------------------------------------------------------
// Relay stuck monitor
// Qualifies stuck relays while the motor idles and times motor runs.
// ----------------------------------------------------------------------------
`include "relay_stuck_monitor_assert.svh"

module relay_stuck_monitor
  import rsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  output logic [PDATA_BITS-1:0] prdata,
  output logic                  pready,
  rsm_tick_if.sink              tick,
  rsm_result_if.source          result
);

  rsm_cfg_t    cfg;
  logic        q_push;
  logic        q_pop;
  rsm_cls_t    q_in;
  rsm_cls_t    q_out;
  rsm_q_stat_t q_stat;
  logic [1:0]  reg_sel;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.stuck_confirm <= STUCK_CONFIRM_RST;
      cfg.stuck_hold    <= STUCK_HOLD_RST;
      cfg.retry_limit   <= RETRY_LIMIT_RST;
      cfg.run_limit     <= RUN_LIMIT_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_STUCK_CONFIRM: cfg.stuck_confirm <= pwdata[7:0];
        REG_STUCK_HOLD:    cfg.stuck_hold    <= pwdata[7:0];
        REG_RETRY_LIMIT:   cfg.retry_limit   <= pwdata[7:0];
        REG_RUN_LIMIT:     cfg.run_limit     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_STUCK_CONFIRM: prdata = PDATA_BITS'(cfg.stuck_confirm);
      REG_STUCK_HOLD:    prdata = PDATA_BITS'(cfg.stuck_hold);
      REG_RETRY_LIMIT:   prdata = PDATA_BITS'(cfg.retry_limit);
      REG_RUN_LIMIT:     prdata = PDATA_BITS'(cfg.run_limit);
      default:           prdata = '0;
    endcase
  end

  rsm_front u_front (
    .tick    (tick),
    .q_ready (!q_stat.full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  rsm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  rsm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .q_stat (q_stat),
    .q_data (q_out),
    .q_pop  (q_pop),
    .result (result)
  );

  // A timeout only happens while the motor runs, when the qualifiers are frozen.
  `RSM_ASSERT_SAME(a_timeout_frozen, clk, rst, result.valid && result.data.run_timeout, !result.data.block_motor && !result.data.mark_released)
  `RSM_ASSERT_SAME(a_exit_cause, clk, rst, result.valid && result.data.normalize_exit, result.data.block_motor || result.data.run_timeout)
  `RSM_ASSERT_NEXT(a_queue_holds, clk, rst, q_push && !q_pop, !q_stat.empty)

endmodule

### tb/sv/rsm_tick_checker.sv
// ----------------------------------------------------------------------------
// Relay stuck monitor checker
// Snoops register writes and the tick and result channels. It keeps its own
// copy of the relay qualifiers and the run timer, works out the flags that
// each accepted tick should give, and compares every accepted result with
// the oldest flags still due.
// ----------------------------------------------------------------------------
module rsm_tick_checker
  import rsm_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [PADDR_BITS-1:0] paddr,
  input  logic [PDATA_BITS-1:0] pwdata,
  rsm_tick_if                   tick,
  rsm_result_if                 result,
  output int                    flags_pending,
  output int                    mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  rsm_cfg_t    cfg;
  logic [7:0]  qual_cnt [2];
  logic        marked [2];
  logic [7:0]  releases [2];
  logic [15:0] run_ticks;
  rsm_result_t flags_due [$];
  int          err_count;

  function automatic rsm_result_t advance_monitor(rsm_tick_t t);
    rsm_result_t         r;
    logic [ADC_BITS-1:0] thr;
    logic [1:0]          cmd;
    logic [1:0]          phys;
    logic                became;
    logic                released;
    logic                timeout;
    thr      = ADC_BITS'(t.battery_raw / 6);
    cmd      = {t.logic_on_b, t.logic_on_a};
    phys[0]  = t.feedback_a > thr;
    phys[1]  = t.feedback_b > thr;
    became   = 1'b0;
    released = 1'b0;
    timeout  = 1'b0;
    if (!t.motor_running) begin
      for (int i = 0; i < 2; i++) begin
        if (!marked[i]) begin
          if (!cmd[i]) begin
            if (phys[i]) begin
              if (qual_cnt[i] < cfg.stuck_confirm) qual_cnt[i] = qual_cnt[i] + 8'd1;
              if (qual_cnt[i] >= cfg.stuck_confirm) begin
                marked[i]   = 1'b1;
                qual_cnt[i] = cfg.stuck_hold;
                became      = 1'b1;
              end
            end else if (qual_cnt[i] != 8'd0) begin
              qual_cnt[i] = qual_cnt[i] - 8'd1;
            end
          end
        end else if (qual_cnt[i] != 8'd0) begin
          qual_cnt[i] = qual_cnt[i] - 8'd1;
        end else if (releases[i] < cfg.retry_limit) begin
          releases[i] = releases[i] + 8'd1;
          marked[i]   = 1'b0;
          released    = 1'b1;
        end
      end
      run_ticks = '0;
    end else if (run_ticks < cfg.run_limit) begin
      run_ticks = run_ticks + 16'd1;
    end else begin
      timeout   = 1'b1;
      run_ticks = '0;
    end
    r.phys_on_a      = phys[0];
    r.phys_on_b      = phys[1];
    r.stuck_a        = marked[0];
    r.stuck_b        = marked[1];
    r.wake_hold      = marked[0] | marked[1];
    r.block_motor    = became;
    r.mark_released  = released;
    r.normalize_exit = became | timeout;
    r.run_timeout    = timeout;
    return r;
  endfunction

  function automatic int flag_differs(string field, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", field, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    rsm_result_t want;
    rsm_result_t got;
    if (rst) begin
      cfg.stuck_confirm = STUCK_CONFIRM_RST;
      cfg.stuck_hold    = STUCK_HOLD_RST;
      cfg.retry_limit   = RETRY_LIMIT_RST;
      cfg.run_limit     = RUN_LIMIT_RST;
      for (int i = 0; i < 2; i++) begin
        qual_cnt[i] = '0;
        marked[i]   = 1'b0;
        releases[i] = '0;
      end
      run_ticks = '0;
      flags_due.delete();
      err_count = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_BITS-1:2])
          REG_STUCK_CONFIRM: cfg.stuck_confirm = pwdata[7:0];
          REG_STUCK_HOLD:    cfg.stuck_hold    = pwdata[7:0];
          REG_RETRY_LIMIT:   cfg.retry_limit   = pwdata[7:0];
          REG_RUN_LIMIT:     cfg.run_limit     = pwdata[15:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        got = result.data;
        if (flags_due.size() == 0) begin
          $error("result accepted with no request waiting for it");
          err_count++;
        end else begin
          want = flags_due.pop_front();
          err_count += flag_differs("phys_on_a", want.phys_on_a, got.phys_on_a);
          err_count += flag_differs("phys_on_b", want.phys_on_b, got.phys_on_b);
          err_count += flag_differs("stuck_a", want.stuck_a, got.stuck_a);
          err_count += flag_differs("stuck_b", want.stuck_b, got.stuck_b);
          err_count += flag_differs("wake_hold", want.wake_hold, got.wake_hold);
          err_count += flag_differs("block_motor", want.block_motor, got.block_motor);
          err_count += flag_differs("mark_released", want.mark_released,
                                    got.mark_released);
          err_count += flag_differs("normalize_exit", want.normalize_exit,
                                    got.normalize_exit);
          err_count += flag_differs("run_timeout", want.run_timeout, got.run_timeout);
        end
      end
      if (tick.valid && tick.ready) flags_due.push_back(advance_monitor(tick.data));
    end
    flags_pending <= flags_due.size();
    mismatches    <= err_count;
  end

endmodule

### tb/sv/tb_relay_stuck_monitor.sv
// ----------------------------------------------------------------------------
// Relay stuck monitor testbench
// Drives directed and random ticks through the monitor under several register
// settings, with random gaps on both channels and one long result stall that
// backs the monitor up. The checker beside the block does the comparison.
// ----------------------------------------------------------------------------
module tb_relay_stuck_monitor;
  import rsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RX_HOLD_CYCLES = 300;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [PADDR_BITS-1:0] paddr;
  logic [PDATA_BITS-1:0] pwdata;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  int                    flags_pending;
  int                    mismatches;

  bit                    tx_calm;
  bit                    rx_calm;
  int                    hold_asked;
  int                    flip_pct;
  int                    run_pct;
  int                    run_left;
  logic [1:0]            want_on;

  rsm_tick_if   tick_ch ();
  rsm_result_if result_ch ();

  relay_stuck_monitor uut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .tick    (tick_ch),
    .result  (result_ch)
  );

  rsm_tick_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .tick          (tick_ch),
    .result        (result_ch),
    .flags_pending (flags_pending),
    .mismatches    (mismatches)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int hold_served;
    hold_served = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_asked) begin
        hold_served++;
        result_ch.ready <= 1'b0;
        repeat (RX_HOLD_CYCLES - 1) @(posedge clk);
      end else if (rx_calm) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= 9);
      end
    end
  end

  task automatic send_tick(input logic [ADC_BITS-1:0] fa, input logic [ADC_BITS-1:0] fb,
                           input logic [ADC_BITS-1:0] bat, input logic cmd_a,
                           input logic cmd_b, input logic running);
    rsm_tick_t t;
    t.feedback_a    = fa;
    t.feedback_b    = fb;
    t.battery_raw   = bat;
    t.logic_on_a    = cmd_a;
    t.logic_on_b    = cmd_b;
    t.motor_running = running;
    if (!tx_calm && $urandom_range(99) < 9) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid <= 1'b1;
    tick_ch.data  <= t;
    do @(posedge clk); while (!tick_ch.ready);
  endtask

  task automatic wait_quiet();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (flags_pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [PDATA_BITS-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic set_limits(input int confirm, input int hold, input int retry,
                            input int run_max);
    wait_quiet();
    write_reg(REG_STUCK_CONFIRM, confirm);
    write_reg(REG_STUCK_HOLD, hold);
    write_reg(REG_RETRY_LIMIT, retry);
    write_reg(REG_RUN_LIMIT, run_max);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Each relay follows a slowly changing wish to read on or off, so that the
  // qualifier counters build up rather than dither; the motor runs in bursts.
  task automatic run_random(input int n);
    logic [ADC_BITS-1:0] bat;
    logic [ADC_BITS-1:0] thr;
    logic [ADC_BITS-1:0] fb [2];
    for (int k = 0; k < n; k++) begin
      if (run_left != 0) run_left--;
      else if ($urandom_range(99) < run_pct) run_left = $urandom_range(1, 30);
      for (int i = 0; i < 2; i++) begin
        if ($urandom_range(99) < flip_pct) want_on[i] = ~want_on[i];
      end
      case ($urandom_range(9))
        0:       bat = '0;
        1:       bat = '1;
        default: bat = ADC_BITS'($urandom_range(4095));
      endcase
      thr = ADC_BITS'(bat / 6);
      for (int i = 0; i < 2; i++) begin
        case ($urandom_range(19))
          0:       fb[i] = ADC_BITS'($urandom_range(4095));
          1:       fb[i] = want_on[i] ? ADC_BITS'(thr + 1) : thr;
          default: fb[i] = want_on[i] ? ADC_BITS'($urandom_range(4095, thr + 1))
                                      : ADC_BITS'($urandom_range(thr, 0));
        endcase
      end
      send_tick(fb[0], fb[1], bat, $urandom_range(99) < 20, $urandom_range(99) < 20,
                run_left != 0);
    end
  endtask

  initial begin
    rst           <= 1'b1;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    tick_ch.valid <= 1'b0;
    tick_ch.data  <= '0;
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    hold_asked = 0;
    flip_pct   = 8;
    run_pct    = 10;
    run_left   = 0;
    want_on    = 2'b00;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Short confirm and hold, one release allowed, run limit of two.
    set_limits(2, 1, 1, 2);
    send_tick(12'd4095, 12'd4095, 12'd4095, 1'b1, 1'b1, 1'b1);
    send_tick(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_tick(12'd4095, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_tick(12'd0, 12'd4095, 12'd4095, 1'b1, 1'b0, 1'b0);
    send_tick(12'd683, 12'd682, 12'd4095, 1'b0, 1'b0, 1'b0);
    // Qualifiers must stay frozen while the motor runs into its timeout.
    send_tick(12'd4095, 12'd4095, 12'd0, 1'b0, 1'b0, 1'b1);
    send_tick(12'd4095, 12'd4095, 12'd0, 1'b0, 1'b0, 1'b1);
    send_tick(12'd4095, 12'd4095, 12'd0, 1'b0, 1'b0, 1'b1);
    send_tick(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_tick(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_tick(12'd4095, 12'd4095, 12'd6, 1'b0, 1'b0, 1'b0);
    send_tick(12'd4095, 12'd4095, 12'd6, 1'b0, 1'b0, 1'b0);
    send_tick(12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 1'b0);
    send_tick(12'd0, 12'd0, 12'd0, 1'b1, 1'b1, 1'b0);
    send_tick(12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 1'b0);
    send_tick(12'd1, 12'd2, 12'd11, 1'b0, 1'b1, 1'b0);

    set_limits(3, 5, 6, 12);
    run_random(100);
    tx_calm = 1'b1;
    rx_calm = 1'b1;
    run_random(150);
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    run_random(50);

    // Largest settings: hold both relays reading on for long enough to mark them.
    set_limits(255, 255, 255, 65535);
    flip_pct = 0;
    run_pct  = 0;
    run_left = 0;
    want_on  = 2'b11;
    run_random(400);

    set_limits($urandom_range(1, 6), $urandom_range(0, 8), $urandom_range(8, 255),
               $urandom_range(0, 20));
    flip_pct = 10;
    run_pct  = 12;
    run_random(80);
    hold_asked++;
    run_random(170);

    set_limits(0, 0, 0, 0);
    flip_pct = 15;
    run_pct  = 15;
    run_random(200);

    set_limits(STUCK_CONFIRM_RST, STUCK_HOLD_RST, RETRY_LIMIT_RST, RUN_LIMIT_RST);
    flip_pct = 8;
    run_pct  = 10;
    run_random(150);

    wait_quiet();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
